FILE: rtl/core/pba_pkg.sv
// Shared types, codes and constants of the page bitmap allocator.
`timescale 1ns / 1ps
`default_nettype none

package pba_pkg;

    // Default geometry
    localparam int PAGES_DEF         = 1024;
    localparam int MAP_WORD_BITS_DEF = 32;

    // Bits of one map word examined per search cycle
    localparam int SCAN_BITS = 8;

    // Field widths
    localparam int REQ_W    = 3;
    localparam int PAGE_W   = 10;
    localparam int CNT_W    = 11;
    localparam int STAT_W   = 2;
    localparam int CFG_IX_W = 2;
    localparam int CFG_D_W  = 11;
    localparam int RLOW_W   = 11;
    localparam int KSTART_W = 11;
    localparam int KEND_W   = 10;

    // Stream widths; the data fields are padded to whole bytes
    localparam int IN_DATA_W  = 24;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 16;
    localparam int OUT_USER_W = 2;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_ALLOC  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_FREE   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_PROBE  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_MARK   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_UNMARK = 3'd4;
    localparam logic [REQ_W-1:0] REQ_INIT   = 3'd5;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_RUN    = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_ALLOC = 2'd2;
    localparam logic [STAT_W-1:0] ST_BOUNDS    = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IX_W-1:0] CFG_RLOW   = 2'd0;
    localparam logic [CFG_IX_W-1:0] CFG_KSTART = 2'd1;
    localparam logic [CFG_IX_W-1:0] CFG_KEND   = 2'd2;

    // Configuration reset values
    localparam logic [RLOW_W-1:0]   RLOW_RST   = 11'd256;
    localparam logic [KSTART_W-1:0] KSTART_RST = 11'd768;
    localparam logic [KEND_W-1:0]   KEND_RST   = 10'd800;

    // Controller to datapath
    typedef struct packed {
        logic start;      // latch a new request
        logic rd_en;      // read one map word
        logic sweep;      // the read word is rewritten next cycle
        logic scan;       // run the search over one slice
        logic set_range;  // load the found run as the range to mark
        logic load_out;   // move the finished result to the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_find;    // alloc or probe
        logic is_sweep;   // request rewrites the map
        logic is_alloc;
        logic found;      // search has hit a run
        logic eval_ok;    // found run passes the start and top checks
        logic out_free;   // output register can take a result
    } t_sts;

endpackage

`default_nettype wire

FILE: rtl/core/pba_ctrl.sv
// Sequencing state machine of the page bitmap allocator.
`timescale 1ns / 1ps
`default_nettype none

module pba_ctrl #(
    parameter int PAGES         = pba_pkg::PAGES_DEF,
    parameter int MAP_WORD_BITS = pba_pkg::MAP_WORD_BITS_DEF,
    localparam int WORDS = (PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS,
    localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1,
    localparam int NCH   = MAP_WORD_BITS / pba_pkg::SCAN_BITS,
    localparam int CHW   = (NCH > 1) ? $clog2(NCH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire pba_pkg::t_sts i_sts,
    output pba_pkg::t_cmd      o_cmd,
    output logic [WAW-1:0]     o_rd_addr,
    output logic [CHW-1:0]     o_chunk
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_EVAL   = 3'd3;
    localparam logic [2:0] S_SWEEP  = 3'd4;
    localparam logic [2:0] S_DRAIN  = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    localparam logic [WAW-1:0] LAST_WORD  = WAW'(WORDS - 1);
    localparam logic [CHW-1:0] LAST_CHUNK = CHW'(NCH - 1);

    logic [2:0]     r_state, n_state;
    logic [WAW-1:0] r_wa, n_wa;
    logic [CHW-1:0] r_ch, n_ch;

    assign o_in_ready = (r_state == S_IDLE);
    assign o_chunk    = r_ch;

    always_comb begin
        n_state   = r_state;
        n_wa      = r_wa;
        n_ch      = r_ch;
        o_cmd     = '0;
        o_rd_addr = r_wa;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                n_wa = '0;
                n_ch = '0;
                if (i_sts.is_find) begin
                    o_cmd.rd_en = 1'b1;
                    o_rd_addr   = '0;
                    n_state     = S_SCAN;
                end else if (i_sts.is_sweep) begin
                    n_state = S_SWEEP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.found) begin
                    n_state = S_EVAL;
                end else if (r_ch == LAST_CHUNK) begin
                    if (r_wa == LAST_WORD) begin
                        n_state = S_EVAL;
                    end else begin
                        // fetch the next word while the last slice is searched
                        o_cmd.rd_en = 1'b1;
                        o_rd_addr   = r_wa + 1'b1;
                        n_wa        = r_wa + 1'b1;
                        n_ch        = '0;
                    end
                end else begin
                    n_ch = r_ch + 1'b1;
                end
            end
            S_EVAL: begin
                n_wa = '0;
                if (i_sts.eval_ok && i_sts.is_alloc) begin
                    o_cmd.set_range = 1'b1;
                    n_state         = S_SWEEP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SWEEP: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.sweep = 1'b1;
                if (r_wa == LAST_WORD) begin
                    n_state = S_DRAIN;
                end else begin
                    n_wa = r_wa + 1'b1;
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wa    <= '0;
            r_ch    <= '0;
        end else begin
            r_state <= n_state;
            r_wa    <= n_wa;
            r_ch    <= n_ch;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/pba_dpath.sv
// Datapath of the page bitmap allocator: map memory, search, range update, result.
`timescale 1ns / 1ps
`default_nettype none

module pba_dpath #(
    parameter int PAGES         = pba_pkg::PAGES_DEF,
    parameter int MAP_WORD_BITS = pba_pkg::MAP_WORD_BITS_DEF,
    localparam int WORDS = (PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS,
    localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1,
    localparam int NCH   = MAP_WORD_BITS / pba_pkg::SCAN_BITS,
    localparam int CHW   = (NCH > 1) ? $clog2(NCH) : 1
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire pba_pkg::t_cmd                    i_cmd,
    input  wire logic [WAW-1:0]                   i_rd_addr,
    input  wire logic [CHW-1:0]                   i_chunk,
    output pba_pkg::t_sts                         o_sts,
    input  wire logic [pba_pkg::REQ_W-1:0]        i_req_type,
    input  wire logic [pba_pkg::PAGE_W-1:0]       i_start_page,
    input  wire logic [pba_pkg::CNT_W-1:0]        i_page_count,
    input  wire logic                             i_kernel_space,
    input  wire logic                             i_cfg_we,
    input  wire logic [pba_pkg::CFG_IX_W-1:0]     i_cfg_index,
    input  wire logic [pba_pkg::CFG_D_W-1:0]      i_cfg_data,
    input  wire logic                             i_out_ready,
    output logic                                  o_out_valid,
    output logic [pba_pkg::STAT_W-1:0]            o_status,
    output logic [pba_pkg::PAGE_W-1:0]            o_result_page
);

    localparam int W      = MAP_WORD_BITS;
    localparam int SB     = pba_pkg::SCAN_BITS;
    localparam int LOG_W  = $clog2(W);
    localparam int LOG_SB = $clog2(SB);
    localparam int PW     = $clog2(PAGES);
    // page arithmetic width: covers start + count and any page index
    localparam int SW     = ((PW > pba_pkg::CNT_W) ? PW : pba_pkg::CNT_W) + 1;
    localparam logic [SW-1:0] PAGES_S = SW'(PAGES);

    // map memory with one valid bit per word
    logic [W-1:0]     mem [WORDS];
    logic [WORDS-1:0] r_vld;
    logic [W-1:0]     r_rdata;
    logic             r_rvld;
    logic [WAW-1:0]   r_wa_q;
    logic             r_wv;

    // request
    logic [pba_pkg::REQ_W-1:0] r_req;
    logic [pba_pkg::CNT_W-1:0] r_cnt;
    logic                      r_ks;
    logic [SW-1:0]             r_lo, r_hi;
    logic                      r_err, n_err;

    // search
    logic [SW-1:0] r_run, n_run;
    logic [SW-1:0] r_at, n_at;
    logic          r_found, n_found;

    // configuration
    logic [pba_pkg::RLOW_W-1:0]   r_rlow;
    logic [pba_pkg::KSTART_W-1:0] r_kstart;
    logic [pba_pkg::KEND_W-1:0]   r_kend;

    // output register
    logic                       r_out_v;
    logic [pba_pkg::STAT_W-1:0] r_status, fin_status;
    logic [pba_pkg::PAGE_W-1:0] r_result, fin_result;

    logic [W-1:0]  rword, rng, ini, bad, below, clrm, wdata;
    logic [SW-1:0] cnt_x, word_base, scan_base, at_end;
    logic [SB-1:0] slice;
    logic          is_find, eval_ok;

    assign cnt_x     = SW'(r_cnt);
    assign rword     = r_rvld ? r_rdata : '0;
    assign word_base = SW'(r_wa_q) << LOG_W;
    assign scan_base = word_base + (SW'(i_chunk) << LOG_SB);
    assign slice     = rword[i_chunk*SB +: SB];
    assign at_end    = r_at + cnt_x;
    assign is_find   = (r_req == pba_pkg::REQ_ALLOC) || (r_req == pba_pkg::REQ_PROBE);
    assign eval_ok   = r_found && (r_at != '0) && (at_end < PAGES_S);

    always_comb begin
        o_sts.is_find  = is_find;
        o_sts.is_alloc = (r_req == pba_pkg::REQ_ALLOC);
        o_sts.found    = r_found;
        o_sts.eval_ok  = eval_ok;
        o_sts.out_free = !r_out_v || i_out_ready;
        unique case (r_req)
            pba_pkg::REQ_FREE,
            pba_pkg::REQ_INIT:   o_sts.is_sweep = 1'b1;
            pba_pkg::REQ_MARK:   o_sts.is_sweep = (r_hi < PAGES_S);
            pba_pkg::REQ_UNMARK: o_sts.is_sweep = (r_hi <= PAGES_S);
            default:             o_sts.is_sweep = 1'b0;
        endcase
    end

    // first-fit search over one slice, page by page
    always_comb begin
        n_run   = r_run;
        n_found = r_found;
        n_at    = r_at;
        for (int k = 0; k < SB; k++) begin : g_step
            logic [SW-1:0] pg;
            pg = scan_base + SW'(k);
            if (!n_found && (pg < PAGES_S)) begin
                if (slice[k]) begin
                    n_run = '0;
                end else begin
                    n_run = n_run + 1'b1;
                end
                if ((r_cnt != '0) && (n_run == cnt_x)) begin
                    n_found = 1'b1;
                    n_at    = pg + 1'b1 - cnt_x;
                end
            end
        end
    end

    // per-page range and init masks of the word in flight
    always_comb begin
        for (int j = 0; j < W; j++) begin : g_bit
            logic [SW-1:0] pg;
            pg     = word_base + SW'(j);
            rng[j] = (pg >= r_lo) && (pg < r_hi) && (pg < PAGES_S);
            if (r_ks) begin
                ini[j] = (pg < PAGES_S) && (pg <= SW'(r_kend) + 1'b1);
            end else begin
                ini[j] = (pg < PAGES_S) &&
                         ((pg < SW'(r_rlow)) || (pg >= SW'(r_kstart)));
            end
        end
    end

    // free stops at the first page in range that is not used
    assign bad   = rng & ~rword & {W{!r_err}};
    assign below = (bad - 1'b1) & ~bad;
    assign clrm  = rng & below & {W{!r_err}};

    always_comb begin
        n_err = r_err;
        unique case (r_req)
            pba_pkg::REQ_ALLOC,
            pba_pkg::REQ_MARK:   wdata = rword | rng;
            pba_pkg::REQ_UNMARK: wdata = rword & ~rng;
            pba_pkg::REQ_FREE: begin
                wdata = rword & ~clrm;
                if (bad != '0) begin
                    n_err = 1'b1;
                end
            end
            pba_pkg::REQ_INIT:   wdata = ini;
            default:             wdata = rword;
        endcase
    end

    always_comb begin
        fin_status = pba_pkg::ST_OK;
        fin_result = '0;
        unique case (r_req)
            pba_pkg::REQ_ALLOC,
            pba_pkg::REQ_PROBE: begin
                if (eval_ok) begin
                    fin_result = r_at[pba_pkg::PAGE_W-1:0];
                end else begin
                    fin_status = pba_pkg::ST_NO_RUN;
                end
            end
            pba_pkg::REQ_FREE: begin
                // pages past the top count as not used
                if (r_err || (r_hi > PAGES_S)) begin
                    fin_status = pba_pkg::ST_NOT_ALLOC;
                end
            end
            pba_pkg::REQ_MARK: begin
                if (r_hi >= PAGES_S) begin
                    fin_status = pba_pkg::ST_BOUNDS;
                end
            end
            pba_pkg::REQ_UNMARK: begin
                if (r_hi > PAGES_S) begin
                    fin_status = pba_pkg::ST_BOUNDS;
                end
            end
            default: begin
                fin_status = pba_pkg::ST_OK;
            end
        endcase
    end

    // memory: one read and one write port, registered read
    always_ff @(posedge i_clk) begin
        if (r_wv) begin
            mem[r_wa_q] <= wdata;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
            r_wv   <= 1'b0;
        end else begin
            if (r_wv) begin
                r_vld[r_wa_q] <= 1'b1;
            end
            if (i_cmd.rd_en) begin
                r_rvld <= r_vld[i_rd_addr];
            end
            r_wv <= i_cmd.rd_en && i_cmd.sweep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_wa_q <= i_rd_addr;
        end
        if (i_cmd.start) begin
            r_req <= i_req_type;
            r_cnt <= i_page_count;
            r_ks  <= i_kernel_space;
            r_lo  <= SW'(i_start_page);
            r_hi  <= SW'(i_start_page) + SW'(i_page_count);
            r_run <= '0;
            r_at  <= '0;
        end else if (i_cmd.set_range) begin
            r_lo <= r_at;
            r_hi <= at_end;
        end else if (i_cmd.scan) begin
            r_run <= n_run;
            r_at  <= n_at;
        end
        if (i_cmd.load_out) begin
            r_status <= fin_status;
            r_result <= fin_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found  <= 1'b0;
            r_err    <= 1'b0;
            r_out_v  <= 1'b0;
            r_rlow   <= pba_pkg::RLOW_RST;
            r_kstart <= pba_pkg::KSTART_RST;
            r_kend   <= pba_pkg::KEND_RST;
        end else begin
            if (i_cmd.start) begin
                r_found <= 1'b0;
                r_err   <= 1'b0;
            end else begin
                if (i_cmd.scan) begin
                    r_found <= n_found;
                end
                if (r_wv) begin
                    r_err <= n_err;
                end
            end
            if (i_cmd.load_out) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    pba_pkg::CFG_RLOW:   r_rlow   <= i_cfg_data;
                    pba_pkg::CFG_KSTART: r_kstart <= i_cfg_data;
                    pba_pkg::CFG_KEND:   r_kend   <= i_cfg_data[pba_pkg::KEND_W-1:0];
                    default:             r_rlow   <= r_rlow;
                endcase
            end
        end
    end

    assign o_out_valid   = r_out_v;
    assign o_status      = r_status;
    assign o_result_page = r_result;

endmodule

`default_nettype wire

FILE: rtl/core/page_bitmap_allocator_unit.sv
// Top level of the page bitmap allocator: stream ports, config port, controller and datapath.
`timescale 1ns / 1ps
`default_nettype none

// Page bitmap allocator. Keeps one used/free bit per page in a map memory of
// PAGES/MAP_WORD_BITS words, rounded up, and serves one request per input word: alloc
// (first-fit search, then mark), probe (search only), free (clear until the
// first page that is not used), mark used, mark free and init (clear the map
// and mark the reserved pages). Each request gives exactly one output word,
// carrying a status and a page number. Requests are handled one at a time.
// What each request spends its time on before the result is ready:
//   free, mark, mark free and init: the one-word-per-cycle read-modify-write
//     sweep of the map; out-of-bounds marks and unknown codes skip it.
//   probe: the search, which walks 8 pages per cycle; it stops early at
//     the first fitting run.
//   alloc: the search, then the marking sweep if the found run passes the checks.
// The output register lets the next request start while a result waits.
// The map is clear after reset through per-word valid bits; no clearing
// pass is needed. Configuration writes are always taken (o_cfg_ready is
// high) and must only come while the block is idle.

module page_bitmap_allocator_unit #(
    parameter int PAGES         = pba_pkg::PAGES_DEF,
    parameter int MAP_WORD_BITS = pba_pkg::MAP_WORD_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // request stream
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [9:0] start_page, [20:10] page_count, [21] kernel_space, [23:22] zero
    input  wire logic [pba_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [2:0] req_type
    input  wire logic [pba_pkg::IN_USER_W-1:0]   s_axis_tuser,
    // result stream
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [9:0] result_page, [15:10] zero
    output logic [pba_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    // [1:0] status
    output logic [pba_pkg::OUT_USER_W-1:0]       m_axis_tuser,
    // configuration writes
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [pba_pkg::CFG_IX_W-1:0]    i_cfg_index,
    input  wire logic [pba_pkg::CFG_D_W-1:0]     i_cfg_data
);

    localparam int WORDS = (PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int NCH   = MAP_WORD_BITS / pba_pkg::SCAN_BITS;
    localparam int CHW   = (NCH > 1) ? $clog2(NCH) : 1;

    pba_pkg::t_cmd              cmd;
    pba_pkg::t_sts              sts;
    logic [WAW-1:0]             rd_addr;
    logic [CHW-1:0]             chunk;
    logic [pba_pkg::STAT_W-1:0] status;
    logic [pba_pkg::PAGE_W-1:0] result_page;

    assign o_cfg_ready = 1'b1;

    pba_ctrl #(
        .PAGES         (PAGES),
        .MAP_WORD_BITS (MAP_WORD_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_rd_addr  (rd_addr),
        .o_chunk    (chunk)
    );

    pba_dpath #(
        .PAGES         (PAGES),
        .MAP_WORD_BITS (MAP_WORD_BITS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_rd_addr      (rd_addr),
        .i_chunk        (chunk),
        .o_sts          (sts),
        .i_req_type     (s_axis_tuser[2:0]),
        .i_start_page   (s_axis_tdata[9:0]),
        .i_page_count   (s_axis_tdata[20:10]),
        .i_kernel_space (s_axis_tdata[21]),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_status       (status),
        .o_result_page  (result_page)
    );

    assign m_axis_tdata = {{(pba_pkg::OUT_DATA_W - pba_pkg::PAGE_W){1'b0}}, result_page};
    assign m_axis_tuser = status;

endmodule

`default_nettype wire

FILE: sim/tb_page_bitmap_allocator_unit.sv
// Self-checking testbench of the page bitmap allocator: directed table, then random request mix.
`timescale 1ns / 1ps

module tb_page_bitmap_allocator_unit;

    localparam int NUM_PAGES   = pba_pkg::PAGES_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;
    // longest request is alloc, which searches and then sweeps the map
    localparam int DRAIN_CYCLES = 200;

    // request codes the block must ignore
    localparam logic [pba_pkg::REQ_W-1:0] REQ_UNDEF_A = 3'd6;
    localparam logic [pba_pkg::REQ_W-1:0] REQ_UNDEF_B = 3'd7;

    typedef struct {
        logic [pba_pkg::STAT_W-1:0] status;
        logic [pba_pkg::PAGE_W-1:0] page;
    } t_page_result;

    typedef struct {
        int unsigned run_start;
        int unsigned run_len;
    } t_live_run;

    typedef struct {
        logic [pba_pkg::REQ_W-1:0]  req;
        logic [pba_pkg::PAGE_W-1:0] start;
        logic [pba_pkg::CNT_W-1:0]  count;
        logic                       kspace;
        bit                         typed;   // expectation fixed in the table
        logic [pba_pkg::STAT_W-1:0] status;
        logic [pba_pkg::PAGE_W-1:0] page;
    } t_table_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [pba_pkg::IN_DATA_W-1:0]  s_axis_tdata;
    logic [pba_pkg::IN_USER_W-1:0]  s_axis_tuser;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [pba_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic [pba_pkg::OUT_USER_W-1:0] m_axis_tuser;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [pba_pkg::CFG_IX_W-1:0] i_cfg_index;
    logic [pba_pkg::CFG_D_W-1:0]  i_cfg_data;

    page_bitmap_allocator_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // shadow of the page map and the config registers
    logic [NUM_PAGES-1:0]               used_map;
    logic [pba_pkg::RLOW_W-1:0]         rlow_q;
    logic [pba_pkg::KSTART_W-1:0]       kstart_q;
    logic [pba_pkg::KEND_W-1:0]         kend_q;

    t_page_result pending_results[$];
    t_live_run    live_runs[$];
    t_table_row   dir_rows[$];
    t_page_result got_word;
    t_page_result want_word;

    int  fail_count = 0;
    int  tx_calm    = 0;
    int  rx_wait    = 0;
    int  rx_calm    = 0;
    int  cycle_count = 0;
    bit  hold_off_req = 1'b0;

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    // Serve one request on the shadow map; mirrors the block's semantics.
    task automatic apply_request(input logic [pba_pkg::REQ_W-1:0] req,
                                 input logic [pba_pkg::PAGE_W-1:0] start,
                                 input logic [pba_pkg::CNT_W-1:0] count, input logic kspace,
                                 output logic [pba_pkg::STAT_W-1:0] st,
                                 output logic [pba_pkg::PAGE_W-1:0] pg);
        int unsigned n;
        int unsigned i;
        int unsigned p;
        int unsigned at;
        int unsigned run;
        bit found;
        t_live_run lr;
        n = count;
        st = pba_pkg::ST_OK;
        pg = '0;
        found = 1'b0;
        at = 0;
        run = 0;
        case (req)
            pba_pkg::REQ_ALLOC, pba_pkg::REQ_PROBE: begin
                // first fit: earliest window of n clear pages
                if (n != 0) begin
                    for (i = 0; i < NUM_PAGES && !found; i++) begin
                        if (used_map[i]) run = 0;
                        else run++;
                        if (run == n) begin
                            found = 1'b1;
                            at = i + 1 - n;
                        end
                    end
                end
                // a run at page 0 or touching the top page counts as a miss
                if (!found || at == 0 || at + n >= NUM_PAGES) begin
                    st = pba_pkg::ST_NO_RUN;
                end else begin
                    pg = at[pba_pkg::PAGE_W-1:0];
                    if (req == pba_pkg::REQ_ALLOC) begin
                        for (i = 0; i < n; i++) used_map[at + i] = 1'b1;
                        lr.run_start = at;
                        lr.run_len = n;
                        live_runs.push_back(lr);
                    end
                end
            end
            pba_pkg::REQ_FREE: begin
                // stops at the first clear page; pages past the top read as clear
                for (i = 0; i < n && st == pba_pkg::ST_OK; i++) begin
                    p = start + i;
                    if (p >= NUM_PAGES || !used_map[p]) st = pba_pkg::ST_NOT_ALLOC;
                    else used_map[p] = 1'b0;
                end
            end
            pba_pkg::REQ_MARK: begin
                if (start + n >= NUM_PAGES) st = pba_pkg::ST_BOUNDS;
                else for (i = 0; i < n; i++) used_map[start + i] = 1'b1;
            end
            pba_pkg::REQ_UNMARK: begin
                if (start + n > NUM_PAGES) st = pba_pkg::ST_BOUNDS;
                else for (i = 0; i < n; i++) used_map[start + i] = 1'b0;
            end
            pba_pkg::REQ_INIT: begin
                used_map = '0;
                live_runs.delete();
                if (kspace) begin
                    for (i = 0; i <= kend_q + 1 && i < NUM_PAGES; i++) used_map[i] = 1'b1;
                end else begin
                    for (i = 0; i < rlow_q && i < NUM_PAGES; i++) used_map[i] = 1'b1;
                    for (i = kstart_q; i < NUM_PAGES; i++) used_map[i] = 1'b1;
                end
            end
            default: ;
        endcase
    endtask

    // Offer one request word and hold it until taken. tvalid stays high on return.
    task automatic push_request(input logic [pba_pkg::REQ_W-1:0] req,
                                input logic [pba_pkg::PAGE_W-1:0] start,
                                input logic [pba_pkg::CNT_W-1:0] count, input logic kspace,
                                input bit typed, input logic [pba_pkg::STAT_W-1:0] t_st,
                                input logic [pba_pkg::PAGE_W-1:0] t_pg);
        t_page_result w;
        logic [pba_pkg::STAT_W-1:0] st;
        logic [pba_pkg::PAGE_W-1:0] pg;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, kspace, count, start};
        s_axis_tuser  <= req;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        apply_request(req, start, count, kspace, st, pg);
        w.status = typed ? t_st : st;
        w.page   = typed ? t_pg : pg;
        pending_results.push_back(w);
    endtask

    // Idle cycles between request words: mostly none or short, a few long.
    task automatic sender_gap();
        int unsigned r;
        int unsigned gap;
        gap = 0;
        if (tx_calm > 0) begin
            tx_calm--;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 3) tx_calm = $urandom_range(20, 60);
            else if (r < 60) gap = 0;
            else if (r < 90) gap = $urandom_range(1, 3);
            else if (r < 97) gap = $urandom_range(4, 10);
            else gap = $urandom_range(20, 80);
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_all_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // All three registers back to back; valid stays high across them.
    task automatic write_config(input logic [pba_pkg::CFG_D_W-1:0] rlow,
                                input logic [pba_pkg::CFG_D_W-1:0] kstart,
                                input logic [pba_pkg::CFG_D_W-1:0] kend);
        int k;
        for (k = 0; k < 3; k++) begin
            i_cfg_valid <= 1'b1;
            case (k)
                0: begin
                    i_cfg_index <= pba_pkg::CFG_RLOW;
                    i_cfg_data  <= rlow;
                end
                1: begin
                    i_cfg_index <= pba_pkg::CFG_KSTART;
                    i_cfg_data  <= kstart;
                end
                default: begin
                    i_cfg_index <= pba_pkg::CFG_KEND;
                    i_cfg_data  <= kend;
                end
            endcase
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            case (k)
                0: rlow_q = rlow;
                1: kstart_q = kstart;
                default: kend_q = kend[pba_pkg::KEND_W-1:0];
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    // One random request: mostly alloc/free traffic over live runs, plus noise.
    task automatic random_request();
        int unsigned r;
        int unsigned pick;
        int unsigned s;
        int unsigned c;
        t_live_run lr;
        logic [pba_pkg::REQ_W-1:0] req;
        r = $urandom_range(0, 99);
        s = $urandom_range(0, NUM_PAGES - 1);
        c = $urandom_range(1, 32);
        req = pba_pkg::REQ_ALLOC;
        if (r < 35) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) c = $urandom_range(1, 16);
            else if (pick < 95) c = $urandom_range(17, 200);
            else c = $urandom_range(0, 2047);
        end else if (r < 55) begin
            req = pba_pkg::REQ_FREE;
            if (live_runs.size() != 0 && $urandom_range(0, 9) != 0) begin
                pick = $urandom_range(0, live_runs.size() - 1);
                lr = live_runs[pick];
                live_runs.delete(pick);
                s = lr.run_start;
                c = lr.run_len;
                // sometimes only part of the run, or overrun its end
                pick = $urandom_range(0, 9);
                if (pick == 0) c = $urandom_range(1, c);
                else if (pick == 1) c = c + $urandom_range(1, 4);
            end
        end else if (r < 63) begin
            req = pba_pkg::REQ_PROBE;
            c = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 64);
        end else if (r < 77) begin
            req = (r < 70) ? pba_pkg::REQ_MARK : pba_pkg::REQ_UNMARK;
            pick = $urandom_range(0, 99);
            // probe the bound: start+count at the top page, one past it or two past it
            if (pick < 25) c = NUM_PAGES - s + $urandom_range(0, 1) - 1 + $urandom_range(0, 1);
            else if (pick < 35) c = $urandom_range(0, 2047);
            else if (pick < 40) c = 0;
        end else if (r < 81) begin
            req = pba_pkg::REQ_INIT;
        end else if (r < 84) begin
            req = $urandom_range(0, 1) ? REQ_UNDEF_A : REQ_UNDEF_B;
            c = $urandom_range(0, 2047);
        end else begin
            req = 3'($urandom_range(0, 7));
            c = $urandom_range(0, 2047);
        end
        push_request(req, s[pba_pkg::PAGE_W-1:0], c[pba_pkg::CNT_W-1:0],
                     1'($urandom_range(0, 1)), 1'b0, '0, '0);
    endtask

    task automatic run_phase(input logic [pba_pkg::CFG_D_W-1:0] rlow,
                             input logic [pba_pkg::CFG_D_W-1:0] kstart,
                             input logic [pba_pkg::CFG_D_W-1:0] kend, input int items,
                             input bit squeeze);
        int k;
        wait_all_results();
        write_config(rlow, kstart, kend);
        if (squeeze) hold_off_req = 1'b1;
        // every phase opens with an init so the new layout takes effect
        push_request(pba_pkg::REQ_INIT, 10'($urandom_range(0, NUM_PAGES - 1)),
                     11'($urandom_range(0, 2047)), 1'($urandom_range(0, 1)), 1'b0, '0, '0);
        for (k = 1; k < items; k++) begin
            // while the receiver holds off, keep offering back to back
            if (!(squeeze && k < 24)) sender_gap();
            random_request();
        end
    endtask

    task automatic add_row(input logic [pba_pkg::REQ_W-1:0] req, input int unsigned start,
                           input int unsigned count, input logic kspace, input bit typed,
                           input logic [pba_pkg::STAT_W-1:0] st, input int unsigned pg);
        t_table_row row;
        row.req    = req;
        row.start  = start[pba_pkg::PAGE_W-1:0];
        row.count  = count[pba_pkg::CNT_W-1:0];
        row.kspace = kspace;
        row.typed  = typed;
        row.status = st;
        row.page   = pg[pba_pkg::PAGE_W-1:0];
        dir_rows.push_back(row);
    endtask

    // Receiver: short random stalls, rare long ones, calm stretches, and the
    // long hold-off on request from the sender side.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                rx_wait = 400;
            end
            if (rx_wait > 0) begin
                m_axis_tready <= 1'b0;
                rx_wait--;
            end else begin
                m_axis_tready <= 1'b1;
                if (rx_calm > 0) begin
                    rx_calm--;
                end else begin
                    case ($urandom_range(0, 99))
                        0, 1:          rx_calm = $urandom_range(50, 200);
                        2, 3, 4:       rx_wait = $urandom_range(20, 60);
                        default: begin
                            if ($urandom_range(0, 99) < 25) rx_wait = $urandom_range(1, 3);
                        end
                    endcase
                end
            end
        end
    end

    // Result check against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && m_axis_tvalid && m_axis_tready) begin
            got_word.status = m_axis_tuser[pba_pkg::STAT_W-1:0];
            got_word.page   = m_axis_tdata[pba_pkg::PAGE_W-1:0];
            if (pending_results.size() == 0) begin
                flag_mismatch("unexpected result word, status", got_word.status, -1);
            end else begin
                want_word = pending_results.pop_front();
                if (got_word.status !== want_word.status)
                    flag_mismatch("status", got_word.status, want_word.status);
                if (got_word.page !== want_word.page)
                    flag_mismatch("result_page", got_word.page, want_word.page);
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t ns: timeout, %0d results outstanding", $time, pending_results.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        int k;
        logic [pba_pkg::CFG_D_W-1:0] rl;
        logic [pba_pkg::CFG_D_W-1:0] ks;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        i_rst_n       = 1'b0;
        used_map = '0;
        rlow_q   = pba_pkg::RLOW_RST;
        kstart_q = pba_pkg::KSTART_RST;
        kend_q   = pba_pkg::KEND_RST;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, reset config (256 / 768 / 800); map is clear after reset.
        add_row(pba_pkg::REQ_PROBE,  0,    0,    0, 1, pba_pkg::ST_NO_RUN,    0);  // zero count
        // run would start at page 0
        add_row(pba_pkg::REQ_ALLOC,  0,    1,    0, 1, pba_pkg::ST_NO_RUN,    0);
        add_row(pba_pkg::REQ_INIT,   0,    0,    0, 1, pba_pkg::ST_OK,        0);  // user layout
        add_row(pba_pkg::REQ_ALLOC,  0,    1,    0, 1, pba_pkg::ST_OK,        256);
        add_row(pba_pkg::REQ_PROBE,  0,    1,    0, 1, pba_pkg::ST_OK,        257);
        // hole is 511 pages
        add_row(pba_pkg::REQ_ALLOC,  0,    512,  0, 1, pba_pkg::ST_NO_RUN,    0);
        add_row(pba_pkg::REQ_ALLOC,  0,    511,  0, 1, pba_pkg::ST_OK,        257);
        add_row(pba_pkg::REQ_PROBE,  0,    1,    0, 1, pba_pkg::ST_NO_RUN,    0);  // map full
        add_row(pba_pkg::REQ_FREE,   256,  1,    0, 1, pba_pkg::ST_OK,        0);
        // double free
        add_row(pba_pkg::REQ_FREE,   256,  1,    0, 1, pba_pkg::ST_NOT_ALLOC, 0);
        // end at the top page
        add_row(pba_pkg::REQ_MARK,   1023, 1,    0, 1, pba_pkg::ST_BOUNDS,    0);
        // same range is legal here
        add_row(pba_pkg::REQ_UNMARK, 1023, 1,    0, 1, pba_pkg::ST_OK,        0);
        add_row(pba_pkg::REQ_UNMARK, 1000, 25,   0, 1, pba_pkg::ST_BOUNDS,    0);
        add_row(pba_pkg::REQ_MARK,   0,    0,    0, 1, pba_pkg::ST_OK,        0);
        add_row(pba_pkg::REQ_INIT,   0,    0,    0, 1, pba_pkg::ST_OK,        0);
        // free runs past the top
        add_row(pba_pkg::REQ_FREE,   1020, 5,    0, 1, pba_pkg::ST_NOT_ALLOC, 0);
        add_row(REQ_UNDEF_A,         0,    0,    0, 1, pba_pkg::ST_OK,        0);
        add_row(REQ_UNDEF_B,         1023, 2047, 1, 1, pba_pkg::ST_OK,        0);
        // kernel: pages 0..801
        add_row(pba_pkg::REQ_INIT,   1023, 2047, 1, 1, pba_pkg::ST_OK,        0);
        add_row(pba_pkg::REQ_ALLOC,  0,    2047, 0, 1, pba_pkg::ST_NO_RUN,    0);
        // 802+222 hits the top
        add_row(pba_pkg::REQ_ALLOC,  0,    222,  0, 1, pba_pkg::ST_NO_RUN,    0);
        add_row(pba_pkg::REQ_ALLOC,  0,    221,  0, 1, pba_pkg::ST_OK,        802);
        // whole map
        add_row(pba_pkg::REQ_UNMARK, 0,    1024, 0, 1, pba_pkg::ST_OK,        0);
        add_row(pba_pkg::REQ_MARK,   0,    1023, 0, 0, pba_pkg::ST_OK,        0);
        // stops at page 1023
        add_row(pba_pkg::REQ_FREE,   0,    2047, 0, 1, pba_pkg::ST_NOT_ALLOC, 0);
        // only run starts at 0
        add_row(pba_pkg::REQ_PROBE,  0,    1023, 0, 1, pba_pkg::ST_NO_RUN,    0);

        for (k = 0; k < dir_rows.size(); k++) begin
            push_request(dir_rows[k].req, dir_rows[k].start, dir_rows[k].count,
                         dir_rows[k].kspace, dir_rows[k].typed, dir_rows[k].status,
                         dir_rows[k].page);
            sender_gap();
        end

        // Config extremes: nothing reserved, then everything reserved, then
        // values past the page range. The first phase also fills the block
        // against a long receiver hold-off.
        run_phase(11'd0,    11'd1024, 11'd0,    120, 1'b1);
        run_phase(11'd1024, 11'd0,    11'd1023, 40,  1'b0);
        run_phase(11'd2047, 11'd2047, 11'd1023, 40,  1'b0);
        for (k = 0; k < 3; k++) begin
            rl = ($urandom_range(0, 1) != 0) ? 11'($urandom_range(0, 300))
                                             : 11'($urandom_range(0, 1024));
            ks = 11'($urandom_range(rl, 1024));
            run_phase(rl, ks, 11'($urandom_range(0, 1023)), 130, 1'b0);
        end

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            flag_mismatch("results left over", pending_results.size(), 0);

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/pba_pkg.sv
rtl/core/pba_ctrl.sv
rtl/core/pba_dpath.sv
rtl/core/page_bitmap_allocator_unit.sv
sim/tb_page_bitmap_allocator_unit.sv
